[rtl/bale_pkg.sv]
// Shared constants, types and codes of the bounded array list engine.
package bale_pkg;

    localparam int DEPTH    = 16;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INS_TAIL  = 3'd0,
        OP_INS_HEAD  = 3'd1,
        OP_REM_MATCH = 3'd2,
        OP_REM_MIN   = 3'd3,
        OP_REM_ALL   = 3'd4,
        OP_READ      = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_MIN,
        S_SCAN,
        S_READ
    } t_state;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp_res;

endpackage

[rtl/bale_ram.sv]
// Single-write, single-read list storage with registered read data.
module bale_ram #(
    parameter int DW = 32,
    parameter int AW = 4,
    parameter int N  = 16
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [N];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[rtl/bale_cmp.sv]
// Shared signed compare unit used for match search and minimum search.
module bale_cmp
    import bale_pkg::*;
(
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output t_cmp_res                 o_res
);

    always_comb begin
        o_res.eq = (i_a == i_b);
        o_res.lt = (i_a < i_b);
    end

endmodule

[rtl/bale_ctrl.sv]
// Request sequencer: walks the list one entry per cycle and forms each result word.
module bale_ctrl
    import bale_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           i_op,
    input  logic signed [DATA_W-1:0]  i_value,
    output t_mem_req                  o_mem,
    input  logic [DATA_W-1:0]         i_rd_data,
    output logic signed [DATA_W-1:0]  o_cmp_a,
    output logic signed [DATA_W-1:0]  o_cmp_b,
    input  t_cmp_res                  i_cmp,
    output logic                      o_strobe,
    output logic [STATUS_W-1:0]       o_status,
    output logic [COUNT_W-1:0]        o_count,
    output logic [COUNT_W-1:0]        o_removed,
    output logic signed [DATA_W-1:0]  o_data,
    output logic                      o_last
);

    t_state                   r_state, n_state;
    t_op                      r_op, n_op;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_rd, n_rd;
    logic [CNT_W-1:0]         r_wr, n_wr;
    logic                     r_pv, n_pv;
    logic [ADDR_W-1:0]        r_pidx, n_pidx;
    logic                     r_found, n_found;
    logic signed [DATA_W-1:0] r_best, n_best;
    logic [ADDR_W-1:0]        r_bpos, n_bpos;

    logic                     r_strobe, n_strobe;
    t_status                  r_status, n_status;
    logic [COUNT_W-1:0]       r_ocount, n_ocount;
    logic [COUNT_W-1:0]       r_removed, n_removed;
    logic signed [DATA_W-1:0] r_data, n_data;
    logic                     r_last, n_last;

    logic accept;
    logic full;
    logic empty;
    logic more;
    logic scan_end;
    logic pidx_last;
    logic drop;
    t_op  in_op;

    assign in_op     = t_op'(i_op);
    assign accept    = start && (r_state == S_IDLE);
    assign full      = (r_count == CNT_W'(DEPTH));
    assign empty     = (r_count == '0);
    assign more      = (r_rd < r_count);
    assign scan_end  = !more && !r_pv;
    assign pidx_last = ((CNT_W'(r_pidx) + CNT_W'(1)) == r_count);

    assign o_cmp_a = $signed(i_rd_data);
    assign o_cmp_b = (r_state == S_MIN) ? r_best : r_value;

    always_comb begin
        unique case (r_op)
            OP_REM_MATCH: drop = i_cmp.eq && !r_found;
            OP_REM_ALL:   drop = i_cmp.eq;
            OP_REM_MIN:   drop = (r_pidx == r_bpos);
            default:      drop = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (in_op) inside
                        OP_INS_HEAD: begin
                            if (!full && !empty) begin
                                n_state = S_SHIFT;
                            end
                        end
                        OP_REM_MATCH, OP_REM_ALL: begin
                            if (!empty) begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_REM_MIN: begin
                            if (!empty) begin
                                n_state = S_MIN;
                            end
                        end
                        OP_READ: begin
                            if (!empty) begin
                                n_state = S_READ;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SHIFT: begin
                if (r_rd == '0 && !r_pv) begin
                    n_state = S_IDLE;
                end
            end
            S_MIN: begin
                if (scan_end) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (r_pv && pidx_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op      = r_op;
        n_value   = r_value;
        n_count   = r_count;
        n_rd      = r_rd;
        n_wr      = r_wr;
        n_pv      = 1'b0;
        n_pidx    = r_pidx;
        n_found   = r_found;
        n_best    = r_best;
        n_bpos    = r_bpos;
        n_strobe  = 1'b0;
        n_status  = ST_OK;
        n_removed = '0;
        n_data    = '0;
        n_last    = 1'b1;
        o_mem     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = in_op;
                    n_value = i_value;
                    n_rd    = '0;
                    n_wr    = '0;
                    n_found = 1'b0;
                    unique case (in_op) inside
                        OP_INS_TAIL: begin
                            n_strobe = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem.wr_en   = 1'b1;
                                o_mem.wr_addr = r_count[ADDR_W-1:0];
                                o_mem.wr_data = i_value;
                                n_count       = r_count + CNT_W'(1);
                            end
                        end
                        OP_INS_HEAD: begin
                            if (full) begin
                                n_strobe = 1'b1;
                                n_status = ST_FULL;
                            end else if (empty) begin
                                n_strobe      = 1'b1;
                                o_mem.wr_en   = 1'b1;
                                o_mem.wr_addr = '0;
                                o_mem.wr_data = i_value;
                                n_count       = r_count + CNT_W'(1);
                            end else begin
                                n_rd = r_count;
                            end
                        end
                        OP_REM_MATCH, OP_REM_MIN, OP_REM_ALL, OP_READ: begin
                            if (empty) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end
                        end
                        default: n_strobe = 1'b1;
                    endcase
                end
            end
            S_SHIFT: begin
                if (r_rd != '0) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = ADDR_W'(r_rd - CNT_W'(1));
                    n_rd          = r_rd - CNT_W'(1);
                    n_pv          = 1'b1;
                    n_pidx        = ADDR_W'(r_rd - CNT_W'(1));
                end
                if (r_pv) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_pidx + ADDR_W'(1);
                    o_mem.wr_data = i_rd_data;
                end else if (r_rd == '0) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = '0;
                    o_mem.wr_data = r_value;
                    n_count       = r_count + CNT_W'(1);
                    n_strobe      = 1'b1;
                end
            end
            S_MIN, S_SCAN, S_READ: begin
                if (more) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_rd[ADDR_W-1:0];
                    n_rd          = r_rd + CNT_W'(1);
                    n_pv          = 1'b1;
                    n_pidx        = r_rd[ADDR_W-1:0];
                end
                if (r_state == S_MIN) begin
                    if (r_pv && (r_pidx == '0 || i_cmp.lt)) begin
                        n_best = $signed(i_rd_data);
                        n_bpos = r_pidx;
                    end
                    if (scan_end) begin
                        n_rd = '0;
                        n_wr = '0;
                    end
                end else if (r_state == S_SCAN) begin
                    if (r_pv) begin
                        if (drop) begin
                            n_found = 1'b1;
                        end else begin
                            o_mem.wr_en   = 1'b1;
                            o_mem.wr_addr = r_wr[ADDR_W-1:0];
                            o_mem.wr_data = i_rd_data;
                            n_wr          = r_wr + CNT_W'(1);
                        end
                    end
                    if (scan_end) begin
                        n_strobe  = 1'b1;
                        n_count   = r_wr;
                        n_removed = COUNT_W'(r_count - r_wr);
                        if (r_op == OP_REM_MATCH && !r_found) begin
                            n_status = ST_NOTFOUND;
                        end
                        if (r_op == OP_REM_MIN) begin
                            n_data = r_best;
                        end
                    end
                end else begin
                    if (r_pv) begin
                        n_strobe = 1'b1;
                        n_data   = $signed(i_rd_data);
                        n_last   = pidx_last;
                    end
                end
            end
            default: n_strobe = 1'b0;
        endcase
        n_ocount = COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pv     <= n_pv;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_value   <= n_value;
        r_rd      <= n_rd;
        r_wr      <= n_wr;
        r_pidx    <= n_pidx;
        r_found   <= n_found;
        r_best    <= n_best;
        r_bpos    <= n_bpos;
        r_status  <= n_status;
        r_ocount  <= n_ocount;
        r_removed <= n_removed;
        r_data    <= n_data;
        r_last    <= n_last;
    end

    assign busy      = (r_state != S_IDLE);
    assign o_strobe  = r_strobe;
    assign o_status  = r_status;
    assign o_count   = r_ocount;
    assign o_removed = r_removed;
    assign o_data    = r_data;
    assign o_last    = r_last;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the list depth.");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.wr_en && o_mem.rd_en) |-> (o_mem.wr_addr != o_mem.rd_addr))
        else $error("Read and write hit the same entry in one cycle.");

    a_compact_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_pv) |-> (r_wr <= CNT_W'(r_pidx)))
        else $error("Compaction write pointer passed the read pointer.");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full && (in_op == OP_INS_TAIL || in_op == OP_INS_HEAD))
            |=> (o_strobe && o_status == ST_FULL && $stable(r_count)))
        else $error("Insert into a full list did not report full.");
`endif

endmodule

[rtl/bounded_array_list_engine_unit.sv]
// Top level of the bounded array list engine: storage, compare unit and sequencer.
//
// The block keeps an ordered list of up to DEPTH signed 32-bit words and serves one
// request at a time. Tail inserts, inserts into an empty list, requests that fail at
// once (full or empty) and unused op codes are answered in the cycle after start is
// taken with busy low; otherwise busy is high from the cycle after start is taken until
// the request is finished. The list storage, with one read and one write port and
// registered read data, is walked one entry per cycle: head insert shifts the entries
// up, remove minimum makes a search pass and then a removal pass. Each result word
// appears on the output ports for exactly one cycle with o_strobe high and cannot be
// held off; read-out delivers one word per cycle. A new request may be started in the
// cycle in which the previous final result is shown.
module bounded_array_list_engine_unit
    import bale_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          i_op,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_strobe,
    output logic [STATUS_W-1:0]      o_status,
    output logic [COUNT_W-1:0]       o_count,
    output logic [COUNT_W-1:0]       o_removed,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_last
);

    t_mem_req                 mem_req;
    logic [DATA_W-1:0]        rd_data;
    logic signed [DATA_W-1:0] cmp_a;
    logic signed [DATA_W-1:0] cmp_b;
    t_cmp_res                 cmp_res;

    bale_ram #(
        .DW (DATA_W),
        .AW (ADDR_W),
        .N  (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_req.wr_en),
        .i_wr_addr (mem_req.wr_addr),
        .i_wr_data (mem_req.wr_data),
        .i_rd_en   (mem_req.rd_en),
        .i_rd_addr (mem_req.rd_addr),
        .o_rd_data (rd_data)
    );

    bale_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

    bale_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_op      (i_op),
        .i_value   (i_value),
        .o_mem     (mem_req),
        .i_rd_data (rd_data),
        .o_cmp_a   (cmp_a),
        .o_cmp_b   (cmp_b),
        .i_cmp     (cmp_res),
        .o_strobe  (o_strobe),
        .o_status  (o_status),
        .o_count   (o_count),
        .o_removed (o_removed),
        .o_data    (o_data),
        .o_last    (o_last)
    );

endmodule

[verif/bounded_array_list_engine_unit_tb.sv]
// Self-checking testbench for the bounded array list engine with its own list predictor.
module bounded_array_list_engine_unit_tb
    import bale_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 430;
    localparam int QUIET_TAIL    = 60;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int IMG_DUT       = 0;
    localparam int IMG_GEN       = 1;

    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} t_traffic_mix;

    typedef struct packed {
        t_status                  status;
        logic [COUNT_W-1:0]       count;
        logic [COUNT_W-1:0]       removed;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } t_result_word;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic                     drain;
    } t_list_request;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [OP_W-1:0]          i_op = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     o_strobe;
    logic [STATUS_W-1:0]      o_status;
    logic [COUNT_W-1:0]       o_count;
    logic [COUNT_W-1:0]       o_removed;
    logic signed [DATA_W-1:0] o_data;
    logic                     o_last;

    logic signed [DATA_W-1:0] list_ent [2][DEPTH];
    int                       list_count [2];
    logic signed [DATA_W-1:0] value_pool [4];

    t_list_request request_queue [$];
    t_result_word  expected_results [$];
    t_result_word  predicted_words [DEPTH];
    t_result_word  observed_word;
    t_list_request next_request;
    int            predicted_count;
    int            results_predicted = 0;
    int            results_seen = 0;
    int            idle_left = 0;
    int            gen_items = 0;
    int            error_count = 0;
    int            op_hist [8];
    int            n_full = 0;
    int            n_empty = 0;
    int            n_notfound = 0;
    int unsigned   cycle_count = 0;

    bounded_array_list_engine_unit i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_op      (i_op),
        .i_value   (i_value),
        .o_strobe  (o_strobe),
        .o_status  (o_status),
        .o_count   (o_count),
        .o_removed (o_removed),
        .o_data    (o_data),
        .o_last    (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void apply_request(input int img, input logic [OP_W-1:0] op,
                                          input logic signed [DATA_W-1:0] value,
                                          output t_result_word words [DEPTH],
                                          output int n_words);
        int pos;
        int kept;
        logic signed [DATA_W-1:0] best;
        t_result_word word;
        word.status  = ST_OK;
        word.count   = '0;
        word.removed = '0;
        word.data    = '0;
        word.last    = 1'b1;
        n_words = 1;
        pos = 0;
        case (op) inside
            OP_INS_TAIL, OP_INS_HEAD: begin
                if (list_count[img] >= DEPTH) begin
                    word.status = ST_FULL;
                end else begin
                    if (op == OP_INS_TAIL) begin
                        list_ent[img][list_count[img]] = value;
                    end else begin
                        for (int i = list_count[img]; i > 0; i--)
                            list_ent[img][i] = list_ent[img][i-1];
                        list_ent[img][0] = value;
                    end
                    list_count[img]++;
                end
            end
            OP_REM_MATCH, OP_REM_MIN: begin
                if (list_count[img] == 0) begin
                    word.status = ST_EMPTY;
                end else begin
                    if (op == OP_REM_MATCH) begin
                        while (pos < list_count[img] && list_ent[img][pos] != value)
                            pos++;
                    end else begin
                        best = list_ent[img][0];
                        for (int i = 1; i < list_count[img]; i++) begin
                            if (list_ent[img][i] < best) begin
                                best = list_ent[img][i];
                                pos = i;
                            end
                        end
                        word.data = best;
                    end
                    if (pos == list_count[img]) begin
                        word.status = ST_NOTFOUND;
                    end else begin
                        for (int i = pos; i < list_count[img] - 1; i++)
                            list_ent[img][i] = list_ent[img][i+1];
                        list_count[img]--;
                        word.removed = COUNT_W'(1);
                    end
                end
            end
            OP_REM_ALL: begin
                if (list_count[img] == 0) begin
                    word.status = ST_EMPTY;
                end else begin
                    kept = 0;
                    for (int i = 0; i < list_count[img]; i++) begin
                        if (list_ent[img][i] != value) begin
                            list_ent[img][kept] = list_ent[img][i];
                            kept++;
                        end
                    end
                    word.removed = COUNT_W'(list_count[img] - kept);
                    list_count[img] = kept;
                end
            end
            OP_READ: begin
                if (list_count[img] == 0) begin
                    word.status = ST_EMPTY;
                end else begin
                    n_words = list_count[img];
                    for (int i = 0; i < list_count[img]; i++) begin
                        word.count = COUNT_W'(list_count[img]);
                        word.data  = list_ent[img][i];
                        word.last  = (i == list_count[img] - 1);
                        words[i]   = word;
                    end
                end
            end
            default: ;
        endcase
        word.count = COUNT_W'(list_count[img]);
        if (op != OP_READ || list_count[img] == 0)
            words[0] = word;
    endfunction

    task automatic add_request(input logic [OP_W-1:0] op,
                               input logic signed [DATA_W-1:0] value, input logic drain);
        t_result_word scratch [DEPTH];
        int n_scratch;
        t_list_request req;
        req.op    = op;
        req.value = value;
        req.drain = drain;
        request_queue.push_back(req);
        apply_request(IMG_GEN, op, value, scratch, n_scratch);
        if (op <= OP_READ)
            gen_items++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(input bit want_match);
        int r;
        r = $urandom_range(0, 99);
        if (want_match && list_count[IMG_GEN] > 0 && r < 60)
            return list_ent[IMG_GEN][$urandom_range(0, list_count[IMG_GEN] - 1)];
        if (r < 75)
            return value_pool[$urandom_range(0, 3)];
        if (r < 90)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input t_traffic_mix mix);
        int r;
        r = $urandom_range(0, 99);
        if (mix == MIX_EVEN)
            return OP_W'($urandom_range(0, 5));
        if (mix == MIX_GROW) begin
            if (r < 35) return OP_INS_TAIL;
            if (r < 70) return OP_INS_HEAD;
            if (r < 78) return OP_REM_MATCH;
            if (r < 86) return OP_REM_MIN;
            if (r < 93) return OP_REM_ALL;
            return OP_READ;
        end
        if (r < 10) return OP_INS_TAIL;
        if (r < 20) return OP_INS_HEAD;
        if (r < 45) return OP_REM_MATCH;
        if (r < 70) return OP_REM_MIN;
        if (r < 88) return OP_REM_ALL;
        return OP_READ;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left = 0;
            list_count[IMG_DUT] = 0;
        end else if (!(start && busy)) begin
            if (start) begin
                apply_request(IMG_DUT, i_op, i_value, predicted_words, predicted_count);
                for (int k = 0; k < predicted_count; k++)
                    expected_results.push_back(predicted_words[k]);
                results_predicted += predicted_count;
                op_hist[i_op]++;
                if (request_queue.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
                    idle_left = $urandom_range(1, 16);
            end
            if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (request_queue.size() > 0 &&
                         (!request_queue[0].drain || results_predicted == results_seen)) begin
                next_request = request_queue.pop_front();
                start   <= 1'b1;
                i_op    <= next_request.op;
                i_value <= next_request.value;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                $error("unexpected result word: status %0d, count %0d, data %0d",
                       o_status, o_count, o_data);
                error_count++;
            end else begin
                observed_word = expected_results.pop_front();
                case (observed_word.status)
                    ST_FULL:     n_full++;
                    ST_EMPTY:    n_empty++;
                    ST_NOTFOUND: n_notfound++;
                    default: ;
                endcase
                if (o_status !== observed_word.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           observed_word.status, o_status);
                    error_count++;
                end
                if (o_count !== observed_word.count) begin
                    $error("count mismatch: expected %0d, actual %0d",
                           observed_word.count, o_count);
                    error_count++;
                end
                if (o_removed !== observed_word.removed) begin
                    $error("removed mismatch: expected %0d, actual %0d",
                           observed_word.removed, o_removed);
                    error_count++;
                end
                if (o_data !== observed_word.data) begin
                    $error("data mismatch: expected %0d, actual %0d",
                           $signed(observed_word.data), o_data);
                    error_count++;
                end
                if (o_last !== observed_word.last) begin
                    $error("last mismatch: expected %0d, actual %0d",
                           observed_word.last, o_last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles with %0d result words outstanding",
                     cycle_count, expected_results.size());
            $display("bounded_array_list_engine_unit_tb NOT OK");
            $finish;
        end
    end

    initial begin
        t_traffic_mix mix;
        int seg_left;
        int leftover;
        logic [OP_W-1:0] op;
        bit same_value;

        for (int k = 0; k < 8; k++)
            op_hist[k] = 0;
        list_count[IMG_GEN] = 0;

        add_request(OP_READ, 32'sd0, 1'b0);
        add_request(OP_REM_MATCH, 32'sd0, 1'b0);
        add_request(OP_REM_MIN, 32'sd0, 1'b0);
        add_request(OP_REM_ALL, 32'sd0, 1'b0);
        add_request(OP_INS_TAIL, VAL_MAX, 1'b0);
        add_request(OP_INS_HEAD, VAL_MIN, 1'b0);
        add_request(OP_INS_TAIL, -32'sd1, 1'b0);
        add_request(OP_INS_TAIL, 32'sd0, 1'b0);
        add_request(OP_INS_HEAD, 32'sd3, 1'b0);
        add_request(OP_INS_TAIL, 32'sd3, 1'b0);
        add_request(OP_READ, 32'sd0, 1'b1);
        add_request(OP_REM_MIN, 32'sd0, 1'b0);
        add_request(OP_INS_HEAD, -32'sd1, 1'b0);
        add_request(OP_REM_MIN, 32'sd0, 1'b0);
        add_request(OP_READ, 32'sd0, 1'b0);
        add_request(OP_REM_MATCH, 32'sd12345, 1'b0);
        add_request(OP_REM_MATCH, 32'sd3, 1'b0);
        add_request(OP_REM_ALL, 32'sd9, 1'b0);
        add_request(OP_INS_TAIL, VAL_MAX, 1'b0);
        add_request(OP_REM_ALL, VAL_MAX, 1'b0);
        add_request(OP_UNUSED_A, $urandom, 1'b0);
        add_request(OP_UNUSED_B, $urandom, 1'b0);
        add_request(OP_READ, 32'sd0, 1'b0);

        gen_items = 0;
        mix = MIX_GROW;
        seg_left = 30;
        for (int k = 0; k < 4; k++)
            value_pool[k] = $urandom_range(0, 6) - 3;
        while (gen_items < RANDOM_ITEMS) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(15, 40);
                mix = t_traffic_mix'($urandom_range(0, 2));
                for (int k = 0; k < 4; k++)
                    value_pool[k] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 6) - 3;
                if ($urandom_range(0, 4) == 0) begin
                    same_value = 1'($urandom_range(0, 1));
                    while (list_count[IMG_GEN] < DEPTH + 2) begin
                        add_request($urandom_range(0, 1) ? OP_INS_TAIL : OP_INS_HEAD,
                                    same_value ? value_pool[0] : pick_value(1'b0), 1'b0);
                        if (list_count[IMG_GEN] == DEPTH)
                            break;
                    end
                    add_request(OP_INS_TAIL, pick_value(1'b0), 1'b0);
                    add_request(OP_INS_HEAD, pick_value(1'b0), 1'b0);
                    add_request(OP_READ, $urandom, 1'b0);
                    add_request(OP_REM_ALL, value_pool[0], $urandom_range(0, 3) == 0);
                end
            end
            if ($urandom_range(0, 79) == 0) begin
                add_request($urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B, $urandom, 1'b0);
            end else begin
                op = pick_op(mix);
                add_request(op, pick_value(op == OP_REM_MATCH || op == OP_REM_ALL),
                            $urandom_range(0, 49) == 0);
            end
            seg_left--;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (request_queue.size() != 0 || start || results_predicted != results_seen);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        leftover = expected_results.size();
        if (leftover != 0)
            $error("%0d expected result words never arrived", leftover);

        $display("Requests: tail %0d, head %0d, match %0d, min %0d, all %0d, read %0d,",
                 op_hist[OP_INS_TAIL], op_hist[OP_INS_HEAD], op_hist[OP_REM_MATCH],
                 op_hist[OP_REM_MIN], op_hist[OP_REM_ALL], op_hist[OP_READ],
                 " unused %0d.", op_hist[OP_UNUSED_A] + op_hist[OP_UNUSED_B]);
        $display("Checked %0d result words: %0d full, %0d empty, %0d not-found replies.",
                 results_seen, n_full, n_empty, n_notfound);
        if (error_count == 0 && leftover == 0) begin
            $display("bounded_array_list_engine_unit_tb OK");
        end else begin
            $display("bounded_array_list_engine_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
